[rtl/wilder_rsi_indicator_core_macros.svh]
// ----------------------------------------------------------------------
// wilder_rsi_indicator_core_macros: assertion helpers
// Concurrent checks on the rising clock edge, off while reset is low.
// ----------------------------------------------------------------------
`ifndef WILDER_RSI_INDICATOR_CORE_MACROS_SVH
`define WILDER_RSI_INDICATOR_CORE_MACROS_SVH

// consequent in the same cycle
`define WRI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the next cycle
`define WRI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wri_pkg.sv]
// ----------------------------------------------------------------------
// wri_pkg: shared types and constants
// Payload structs, controller commands, status and state encoding.
// ----------------------------------------------------------------------
package wri_pkg;

  localparam int CLOSE_W    = 32;
  localparam int RSI_W      = 14;
  localparam int RATIO_BITS = 49;
  localparam int PERIOD_W   = 7;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 7'd2;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 7'd64;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 7'd14;

  localparam logic [RSI_W-1:0] RSI_HALF = 14'd5000;
  localparam logic [RSI_W-1:0] RSI_FULL = 14'd10000;

  typedef struct packed {
    logic [CLOSE_W-1:0] close_price;
    logic               restart;
  } wri_in_t;

  typedef struct packed {
    logic [RSI_W-1:0] rsi_hundredths;
    logic             warmed_up;
  } wri_out_t;

  typedef enum logic [1:0] {
    DOP_GAIN,
    DOP_LOSS,
    DOP_RATIO
  } wri_div_op_t;

  typedef struct packed {
    logic zero;
    logic sum;
    logic first;
    logic warm;
  } wri_mode_t;

  typedef struct packed {
    logic        capture;
    logic        add;
    logic        div_start;
    logic        div_wb;
    wri_div_op_t div_op;
    logic        ratio_load;
    logic        norm_shift;
    logic        mul;
    logic        res_load;
  } wri_cmd_t;

  typedef struct packed {
    wri_mode_t mode;
    logic      loss_zero;
    logic      ratio_wide;
    logic      div_busy;
    logic      div_done;
  } wri_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_GAIN_GO,
    S_GAIN_WAIT,
    S_LOSS_GO,
    S_LOSS_WAIT,
    S_CHECK,
    S_NORM,
    S_MUL,
    S_RATIO_GO,
    S_RATIO_WAIT,
    S_DONE
  } wri_state_t;

endpackage

[rtl/wri_div.sv]
// ----------------------------------------------------------------------
// wri_div: shared bit-serial divider
// Restoring division, one quotient bit per cycle, dividend left aligned.
// ----------------------------------------------------------------------
module wri_div #(
  parameter int DDW = 64,
  parameter int DVW = 50
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DDW-1:0]             dividend,
  input  logic [DVW-1:0]             divisor,
  input  logic [$clog2(DDW+1)-1:0]   steps,
  output logic                       busy,
  output logic                       done,
  output logic [DDW-1:0]             quotient,
  output logic                       rem_nz
);

  localparam int CW = $clog2(DDW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DDW-1:0] num_r, num_nxt;
  logic [DDW-1:0] quo_r, quo_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] dvs_r, dvs_nxt;
  logic [DVW:0]   trial;
  logic [DVW:0]   trial_sub;
  logic           take;

  assign trial     = {rem_r, num_r[DDW-1]};
  assign take      = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      num_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      rem_nxt = take ? trial_sub[DVW-1:0] : trial[DVW-1:0];
      quo_nxt = {quo_r[DDW-2:0], take};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = rem_r != '0;

endmodule

[rtl/wri_dp.sv]
// ----------------------------------------------------------------------
// wri_dp: indicator datapath
// Series state, running sums and averages, ratio operands and result.
// ----------------------------------------------------------------------
`include "wilder_rsi_indicator_core_macros.svh"

module wri_dp #(
  parameter int PRICE_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wri_pkg::PERIOD_W-1:0]  cfg_data,
  input  wri_pkg::wri_in_t              in_data,
  input  wri_pkg::wri_cmd_t             cmd,
  output wri_pkg::wri_sts_t             sts,
  output wri_pkg::wri_out_t             out_data
);

  import wri_pkg::*;

  localparam int AVG_W  = PRICE_BITS + FRAC_BITS;
  localparam int FX_W   = AVG_W + FRAC_BITS;
  localparam int PROD_W = RSI_W + RATIO_BITS;
  localparam int DDW    = (FX_W > PROD_W) ? FX_W : PROD_W;
  localparam int DVW    = RATIO_BITS + 1;
  localparam int CW     = $clog2(DDW + 1);
  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic [PRICE_BITS-1:0] prev_r, prev_nxt;
  logic [PERIOD_W-1:0]   bar_r, bar_nxt;
  logic [AVG_W-1:0]      avg_g_r, avg_g_nxt;
  logic [AVG_W-1:0]      avg_l_r, avg_l_nxt;
  wri_mode_t             mode_r, mode_nxt;
  logic [PERIOD_W-1:0]   n_r, n_nxt;
  logic [PRICE_BITS-1:0] gain_r, gain_nxt;
  logic [PRICE_BITS-1:0] loss_r, loss_nxt;
  logic [AVG_W-1:0]      rg_r, rg_nxt;
  logic [AVG_W-1:0]      rl_r, rl_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [DVW-1:0]        den_r, den_nxt;
  logic [RSI_W-1:0]      rsi_q_r, rsi_q_nxt;
  wri_out_t              out_r, out_nxt;

  logic [PRICE_BITS-1:0] close_m;
  logic [PERIOD_W-1:0]   n_clamp;
  logic [PERIOD_W-1:0]   idx;
  logic [AVG_W:0]        sum_g;
  logic [AVG_W:0]        sum_l;
  logic [AVG_W-1:0]      sel_avg;
  logic [PRICE_BITS-1:0] sel_pr;
  logic [AVG_W-1:0]      x_fx;
  logic                  x_ge;
  logic [AVG_W-1:0]      diff;
  logic [FX_W-1:0]       fx_sum;
  logic [AVG_W-1:0]      wb_avg;
  logic [DDW-1:0]        dvd;
  logic [DVW-1:0]        dvs;
  logic [CW-1:0]         steps;
  logic                  div_busy;
  logic                  div_done;
  logic [DDW-1:0]        div_q;
  logic                  div_rnz;

  assign close_m = PRICE_BITS'(in_data.close_price);
  assign n_clamp = (period_r < PERIOD_MIN) ? PERIOD_MIN :
                   (period_r > PERIOD_MAX) ? PERIOD_MAX : period_r;
  assign idx     = in_data.restart ? '0 : bar_r;

  assign sum_g = {1'b0, avg_g_r} + (AVG_W + 1)'(gain_r);
  assign sum_l = {1'b0, avg_l_r} + (AVG_W + 1)'(loss_r);

  // divider operands
  assign sel_avg = (cmd.div_op == DOP_LOSS) ? avg_l_r : avg_g_r;
  assign sel_pr  = (cmd.div_op == DOP_LOSS) ? loss_r : gain_r;
  assign x_fx    = AVG_W'(sel_pr) << FRAC_BITS;
  assign x_ge    = x_fx >= sel_avg;
  assign diff    = x_ge ? (x_fx - sel_avg) : (sel_avg - x_fx);
  assign fx_sum  = {sel_avg, {FRAC_BITS{1'b0}}};

  always_comb begin
    case (cmd.div_op)
      DOP_RATIO: begin
        dvd   = DDW'(prod_r) << (DDW - PROD_W);
        dvs   = den_r;
        steps = CW'(PROD_W);
      end
      default: begin
        dvs = DVW'(n_r);
        if (mode_r.first) begin
          dvd   = DDW'(fx_sum) << (DDW - FX_W);
          steps = CW'(FX_W);
        end else begin
          dvd   = DDW'(diff) << (DDW - AVG_W);
          steps = CW'(AVG_W);
        end
      end
    endcase
  end

  always_comb begin
    if (mode_r.first) begin
      wb_avg = ((div_q >> AVG_W) != '0) ? AVG_MAX : AVG_W'(div_q);
    end else if (x_ge) begin
      wb_avg = sel_avg + AVG_W'(div_q);
    end else begin
      wb_avg = sel_avg - (AVG_W'(div_q) + AVG_W'(div_rnz));
    end
  end

  wri_div #(
    .DDW (DDW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .steps    (steps),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rnz)
  );

  always_comb begin
    period_nxt = cfg_we ? cfg_data : period_r;
    prev_nxt   = prev_r;
    bar_nxt    = bar_r;
    avg_g_nxt  = avg_g_r;
    avg_l_nxt  = avg_l_r;
    mode_nxt   = mode_r;
    n_nxt      = n_r;
    gain_nxt   = gain_r;
    loss_nxt   = loss_r;
    rg_nxt     = rg_r;
    rl_nxt     = rl_r;
    prod_nxt   = prod_r;
    den_nxt    = den_r;
    rsi_q_nxt  = rsi_q_r;
    out_nxt    = out_r;

    if (cmd.capture) begin
      prev_nxt       = close_m;
      n_nxt          = n_clamp;
      bar_nxt        = (idx > n_clamp) ? (n_clamp + 1'b1) : (idx + 1'b1);
      mode_nxt.zero  = idx == '0;
      mode_nxt.sum   = (idx != '0) && (idx <= n_clamp);
      mode_nxt.first = (idx != '0) && (idx == n_clamp);
      mode_nxt.warm  = (idx != '0) && (idx >= n_clamp);
      if (close_m > prev_r) begin
        gain_nxt = close_m - prev_r;
        loss_nxt = '0;
      end else begin
        gain_nxt = '0;
        loss_nxt = prev_r - close_m;
      end
      if (idx == '0) begin
        avg_g_nxt = '0;
        avg_l_nxt = '0;
      end
    end

    // saturating running sums during warm-up
    if (cmd.add) begin
      avg_g_nxt = sum_g[AVG_W] ? AVG_MAX : sum_g[AVG_W-1:0];
      avg_l_nxt = sum_l[AVG_W] ? AVG_MAX : sum_l[AVG_W-1:0];
    end

    if (cmd.div_wb) begin
      case (cmd.div_op)
        DOP_GAIN:  avg_g_nxt = wb_avg;
        DOP_LOSS:  avg_l_nxt = wb_avg;
        DOP_RATIO: rsi_q_nxt = RSI_W'(div_q);
        default:   rsi_q_nxt = rsi_q_r;
      endcase
    end

    if (cmd.ratio_load) begin
      rg_nxt = avg_g_r;
      rl_nxt = avg_l_r;
    end

    if (cmd.norm_shift) begin
      rg_nxt = rg_r >> 1;
      rl_nxt = rl_r >> 1;
    end

    if (cmd.mul) begin
      prod_nxt = PROD_W'(RATIO_BITS'(rg_r)) * PROD_W'(RSI_FULL);
      den_nxt  = DVW'(RATIO_BITS'(rg_r)) + DVW'(RATIO_BITS'(rl_r));
    end

    if (cmd.res_load) begin
      out_nxt.warmed_up = mode_r.warm;
      if (!mode_r.warm) begin
        out_nxt.rsi_hundredths = RSI_HALF;
      end else if (avg_l_r == '0) begin
        out_nxt.rsi_hundredths = RSI_FULL;
      end else begin
        out_nxt.rsi_hundredths = rsi_q_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      prev_r   <= '0;
      bar_r    <= '0;
      avg_g_r  <= '0;
      avg_l_r  <= '0;
      mode_r   <= '0;
    end else begin
      period_r <= period_nxt;
      prev_r   <= prev_nxt;
      bar_r    <= bar_nxt;
      avg_g_r  <= avg_g_nxt;
      avg_l_r  <= avg_l_nxt;
      mode_r   <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    gain_r  <= gain_nxt;
    loss_r  <= loss_nxt;
    rg_r    <= rg_nxt;
    rl_r    <= rl_nxt;
    prod_r  <= prod_nxt;
    den_r   <= den_nxt;
    rsi_q_r <= rsi_q_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    sts.mode       = mode_r;
    sts.loss_zero  = avg_l_r == '0;
    sts.ratio_wide = ((rg_r | rl_r) >> RATIO_BITS) != '0;
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
  end

  assign out_data = out_r;

  `WRI_ASSERT_NOW(a_bar_sat, 1'b1, bar_r <= (PERIOD_MAX + 1'b1), "bar count past saturation")
  `WRI_ASSERT_NOW(a_ratio_range, cmd.div_wb && (cmd.div_op == DOP_RATIO), div_q <= DDW'(RSI_FULL), "ratio quotient above full scale")

endmodule

[rtl/wri_ctrl.sv]
// ----------------------------------------------------------------------
// wri_ctrl: indicator controller
// Sequences capture, sums, the three divisions and the result transfer.
// ----------------------------------------------------------------------
`include "wilder_rsi_indicator_core_macros.svh"

module wri_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  wri_pkg::wri_sts_t  sts,
  output wri_pkg::wri_cmd_t  cmd
);

  import wri_pkg::*;

  wri_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.mode.zero) begin
          state_nxt = S_DONE;
        end else if (sts.mode.sum) begin
          cmd.add   = 1'b1;
          state_nxt = sts.mode.first ? S_GAIN_GO : S_DONE;
        end else begin
          state_nxt = S_GAIN_GO;
        end
      end
      S_GAIN_GO: begin
        cmd.div_op    = DOP_GAIN;
        cmd.div_start = 1'b1;
        state_nxt     = S_GAIN_WAIT;
      end
      S_GAIN_WAIT: begin
        cmd.div_op = DOP_GAIN;
        if (sts.div_done) begin
          cmd.div_wb = 1'b1;
          state_nxt  = S_LOSS_GO;
        end
      end
      S_LOSS_GO: begin
        cmd.div_op    = DOP_LOSS;
        cmd.div_start = 1'b1;
        state_nxt     = S_LOSS_WAIT;
      end
      S_LOSS_WAIT: begin
        cmd.div_op = DOP_LOSS;
        if (sts.div_done) begin
          cmd.div_wb = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.loss_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ratio_load = 1'b1;
          state_nxt      = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.ratio_wide) begin
          cmd.norm_shift = 1'b1;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RATIO_GO;
      end
      S_RATIO_GO: begin
        cmd.div_op    = DOP_RATIO;
        cmd.div_start = 1'b1;
        state_nxt     = S_RATIO_WAIT;
      end
      S_RATIO_WAIT: begin
        cmd.div_op = DOP_RATIO;
        if (sts.div_done) begin
          cmd.div_wb = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `WRI_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
  `WRI_ASSERT_NOW(a_div_free, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `WRI_ASSERT_NOW(a_no_overwrite, cmd.res_load, !out_valid_r || out_ready, "pending result overwritten")

endmodule

[rtl/wilder_rsi_indicator_core.sv]
// ----------------------------------------------------------------------
// wilder_rsi_indicator_core: Wilder RSI, one close in, one value out
// Warm-up bars before the last skip the divisions and go to the result.
// Steady-state bars run the gain, loss and ratio divisions on the
// shared bit-serial divider and skip the ratio when the loss average
// is zero; the bar that ends warm-up runs wider average divisions.
// The next close is taken only once the last result is registered.
// Synchronous active-low reset: period 14, series state cleared.
// ----------------------------------------------------------------------
module wilder_rsi_indicator_core #(
  parameter int PRICE_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wri_pkg::wri_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output wri_pkg::wri_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [wri_pkg::PERIOD_W-1:0] cfg_data
);

  import wri_pkg::*;

  wri_cmd_t cmd;
  wri_sts_t sts;

  wri_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wri_dp #(
    .PRICE_BITS (PRICE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
